// ===== src/dcr_pkg.sv =====
// ----------------------------------------------------------------------------
// dcr_pkg - shared types and constants of the damped comb reverb
// Payload structs, controller/datapath command and status structs,
// register indexes, comb taps and fixed-point coefficient constants.
// ----------------------------------------------------------------------------
package dcr_pkg;

  localparam int SAMPLE_W  = 16;            // Q1.15 audio sample
  localparam int WORD_W    = SAMPLE_W + 4;  // Q5.15 delay word
  localparam int COEF_W    = 16;            // wet, feedback and damping
  localparam int Q16_W     = 17;            // Q0.16 value that may be exactly one
  localparam int Q_SHIFT   = 16;
  localparam int NCOMB     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int ROOM_W    = 12;
  localparam int TAP_W     = 12;

  typedef logic [1:0] comb_idx_t;
  typedef logic [3:0] coef_step_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       frame_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       frame_last;
  } out_item_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INDOOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ABSORB = 2'd2;

  localparam logic [CFG_W-1:0]  INDOOR_RESET = 16'd0;
  localparam logic [ROOM_W-1:0] ROOM_RESET   = 12'd0;
  localparam logic [CFG_W-1:0]  ABSORB_RESET = 16'd32768;

  localparam logic [CFG_W-1:0] BYPASS_LIMIT = 16'd3277;   // 0.05
  localparam logic [CFG_W-1:0] FULL_SCALE   = 16'hFFFF;   // read as exactly one
  localparam logic [Q16_W-1:0] Q16_ONE      = 17'h10000;

  // Room size normalisation: s = floor(room * 8192 / 25), clamped at one
  localparam logic [ROOM_W-1:0] ROOM_NORM        = 12'd200;
  localparam int                ROOM_SMALL_W     = 8;
  localparam int                SIZE_PROD_W      = 30;
  localparam logic [21:0]       K_SIZE_RECIP     = 22'd2684355;  // ceil(2^26 / 25)
  localparam int                SIZE_RECIP_SHIFT = 13;

  localparam logic [TAP_W-1:0] COMB_TAP [NCOMB] = '{12'd1559, 12'd2137, 12'd2909, 12'd3823};

  // Coefficient constants, Q0.16
  localparam logic [Q16_W:0]   K_WET_BASE  = 18'd13107;  // 0.20
  localparam logic [Q16_W-1:0] K_WET_SIZE  = 17'd22938;  // 0.35
  localparam logic [Q16_W:0]   K_WETM_BASE = 18'd19661;  // 0.30
  localparam logic [Q16_W-1:0] K_WETM      = 17'd45875;  // 0.70
  localparam logic [Q16_W:0]   K_FB_BASE   = 18'd22938;  // 0.35
  localparam logic [Q16_W-1:0] K_FB_SIZE   = 17'd26214;  // 0.40
  localparam logic [Q16_W-1:0] K_FB_IND    = 17'd9830;   // 0.15
  localparam logic [Q16_W:0]   K_FBM_BASE  = 18'd26214;  // 0.40
  localparam logic [Q16_W-1:0] K_FBM       = 17'd39322;  // 0.60
  localparam logic [Q16_W:0]   K_DAMP_BASE = 18'd36045;  // 0.55
  localparam logic [Q16_W-1:0] K_DAMP_SIZE = 17'd19661;  // 0.30
  localparam logic [Q16_W-1:0] K_DAMP_ABS  = 17'd13107;  // 0.20

  // Coefficient sequence steps
  localparam coef_step_t CS_SIZE   = 4'd0;
  localparam coef_step_t CS_WET_T1 = 4'd1;
  localparam coef_step_t CS_WET_T2 = 4'd2;
  localparam coef_step_t CS_WET_A  = 4'd3;
  localparam coef_step_t CS_WET    = 4'd4;
  localparam coef_step_t CS_FB_S   = 4'd5;
  localparam coef_step_t CS_FB_A   = 4'd6;
  localparam coef_step_t CS_FB_M   = 4'd7;
  localparam coef_step_t CS_FB     = 4'd8;
  localparam coef_step_t CS_DAMP_S = 4'd9;
  localparam coef_step_t CS_DAMP_B = 4'd10;
  localparam coef_step_t CS_FIRST  = CS_SIZE;
  localparam coef_step_t CS_LAST   = CS_DAMP_B;

  typedef struct packed {
    logic       take;       // input beat accepted
    logic       coef_en;
    coef_step_t coef_step;
    logic       rd_en;      // issue delay read
    comb_idx_t  rd_comb;
    logic       tap_en;     // tap arrives, damping multiply
    comb_idx_t  tap_comb;
    logic       lp_en;      // damping state update
    comb_idx_t  lp_comb;
    logic       fb_en;      // feedback multiply
    logic       wr_en;      // delay write
    comb_idx_t  wr_comb;
    logic       mix_en;     // wet/dry multiply
    logic       y_en;       // mixed sample ready
    logic       pos_adv;
    logic       load_out;
    logic       out_sel_x;  // bypass: send dry sample
  } dcr_cmd_t;

  typedef struct packed {
    logic bypass;
  } dcr_status_t;

endpackage

// ===== src/damped_comb_reverb_core.sv =====
// ----------------------------------------------------------------------------
// damped_comb_reverb_core - four-comb damped reverb, one sample per beat
// Mixes each sample with the averaged taps of four feedback comb filters
// (1559, 2137, 2909, 3823 samples) carrying one-pole damping low-passes.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake               payload
//   in       sink       in_valid / in_ready     in_data  (sample_in, frame_end)
//   out      source     out_valid / out_ready   out_data (sample_out, frame_last)
//   cfg      sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A reverb sample steps through the comb schedule and is loaded into the output
// register, and the next beat is taken on the edge that loads the result: one
// step counter walks the four combs through read, damping multiply, low-pass
// update, feedback multiply and write on the single-write delay memory.
// A bypassed sample (indoor amount below 0.05) skips the comb schedule.
// After reset and after each register write, an 11-step coefficient pass on
// one multiplier runs before in_ready rises. Reset is synchronous.
// The result waits in the output register; a new beat is taken while it does.
//
module damped_comb_reverb_core #(
  parameter int DELAY_DEPTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dcr_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dcr_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dcr_pkg::CFG_W-1:0]      cfg_data
);

  dcr_pkg::dcr_cmd_t    cmd;
  dcr_pkg::dcr_status_t status;
  logic                 cfg_write;

  // Register writes are always taken; a write restarts the coefficient pass
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  dcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_write (cfg_write),
    .status    (status),
    .cmd       (cmd)
  );

  dcr_dpath #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

// ===== src/dcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcr_ctrl - sequencer of the damped comb reverb
// Runs the coefficient pass after reset and register writes, steps each
// reverb sample through the eight-step comb schedule and owns the output valid.
// ----------------------------------------------------------------------------
module dcr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 cfg_write,
  input  dcr_pkg::dcr_status_t status,
  output dcr_pkg::dcr_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_COEF = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam logic [2:0] ST_FIRST  = 3'd0;
  localparam logic [2:0] RD_LAST   = 3'd3;
  localparam logic [2:0] TAP_FIRST = 3'd1;
  localparam logic [2:0] TAP_LAST  = 3'd4;
  localparam logic [2:0] LP_FIRST  = 3'd2;
  localparam logic [2:0] LP_LAST   = 3'd5;
  localparam logic [2:0] FB_FIRST  = 3'd3;
  localparam logic [2:0] FB_LAST   = 3'd6;
  localparam logic [2:0] WR_FIRST  = 3'd4;
  localparam logic [2:0] ST_MIX    = 3'd5;
  localparam logic [2:0] ST_Y      = 3'd6;
  localparam logic [2:0] ST_LAST   = 3'd7;

  logic [1:0]          state, state_next;
  logic [2:0]          step, step_next;
  dcr_pkg::coef_step_t cstep, cstep_next;
  logic                dirty, dirty_next;
  logic                byp, byp_next;
  logic                out_free, finishing, load_out, take, run;

  always_comb begin
    out_free  = !out_valid || out_ready;
    finishing = (state == S_RUN && step == ST_LAST) || state == S_FIN;
    load_out  = finishing && out_free;
    in_ready  = !dirty && (state == S_IDLE || load_out);
    take      = in_valid && in_ready;
    run       = state == S_RUN;
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cstep_next = cstep;
    byp_next   = byp;
    dirty_next = dirty || cfg_write;
    case (state)
      S_IDLE: begin
        if (dirty) begin
          state_next = S_COEF;
          cstep_next = dcr_pkg::CS_FIRST;
        end
      end
      S_COEF: begin
        if (cfg_write) begin
          cstep_next = dcr_pkg::CS_FIRST;
        end else if (cstep == dcr_pkg::CS_LAST) begin
          state_next = S_IDLE;
          dirty_next = 1'b0;
        end else begin
          cstep_next = dcr_pkg::coef_step_t'(cstep + 1'b1);
        end
      end
      S_RUN: begin
        if (step != ST_LAST) begin
          step_next = 3'(step + 1'b1);
        end else if (!out_free) begin
          state_next = S_FIN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (take) begin
      byp_next   = status.bypass;
      step_next  = ST_FIRST;
      state_next = status.bypass ? S_FIN : S_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= ST_FIRST;
      cstep     <= dcr_pkg::CS_FIRST;
      dirty     <= 1'b1;
      byp       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      cstep <= cstep_next;
      dirty <= dirty_next;
      byp   <= byp_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Decode the step into stage enables; comb c enters the read stage at step c
  always_comb begin
    cmd           = '0;
    cmd.take      = take;
    cmd.coef_en   = state == S_COEF && !cfg_write;
    cmd.coef_step = cstep;
    cmd.rd_en     = run && step <= RD_LAST;
    cmd.rd_comb   = step[1:0];
    cmd.tap_en    = run && step >= TAP_FIRST && step <= TAP_LAST;
    cmd.tap_comb  = 2'(step - TAP_FIRST);
    cmd.lp_en     = run && step >= LP_FIRST && step <= LP_LAST;
    cmd.lp_comb   = 2'(step - LP_FIRST);
    cmd.fb_en     = run && step >= FB_FIRST && step <= FB_LAST;
    cmd.wr_en     = run && step >= WR_FIRST;
    cmd.wr_comb   = 2'(step - WR_FIRST);
    cmd.mix_en    = run && step == ST_MIX;
    cmd.y_en      = run && step == ST_Y;
    cmd.pos_adv   = run && step == ST_LAST;
    cmd.load_out  = load_out;
    cmd.out_sel_x = state == S_FIN && byp;
  end

endmodule

// ===== src/dcr_dpath.sv =====
// ----------------------------------------------------------------------------
// dcr_dpath - datapath of the damped comb reverb
// Configuration registers, coefficient unit, delay memory, damping states,
// the shared tap/mix multiplier, the feedback multiplier and output register.
// ----------------------------------------------------------------------------
module dcr_dpath #(
  parameter int DELAY_DEPTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dcr_pkg::in_item_t                   in_data,
  input  logic                                cfg_write,
  input  logic [dcr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dcr_pkg::CFG_W-1:0]           cfg_data,
  input  dcr_pkg::dcr_cmd_t                   cmd,
  output dcr_pkg::dcr_status_t                status,
  output dcr_pkg::out_item_t                  out_data
);

  localparam int SAMPLE_W  = dcr_pkg::SAMPLE_W;
  localparam int WORD_W    = dcr_pkg::WORD_W;
  localparam int COEF_W    = dcr_pkg::COEF_W;
  localparam int Q16_W     = dcr_pkg::Q16_W;
  localparam int Q_SHIFT   = dcr_pkg::Q_SHIFT;
  localparam int DIFF_W    = WORD_W + 1;
  localparam int WIDE_W    = WORD_W + 2;
  localparam int SUM_W     = WORD_W + 2;
  localparam int P1_W      = DIFF_W + COEF_W + 1;
  localparam int P2_W      = WORD_W + COEF_W + 1;
  localparam int CM_W      = 2 * Q16_W;
  localparam int PW        = $clog2(DELAY_DEPTH);
  localparam int PW1       = PW + 1;
  localparam int MEM_DEPTH = dcr_pkg::NCOMB * DELAY_DEPTH;
  localparam int MAW       = $clog2(MEM_DEPTH);

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'((1 << (WORD_W - 1)) - 1);
    lo = WIDE_W'(-(1 << (WORD_W - 1)));
    if (v > hi) begin
      sat_word = hi[WORD_W-1:0];
    end else if (v < lo) begin
      sat_word = lo[WORD_W-1:0];
    end else begin
      sat_word = v[WORD_W-1:0];
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'((1 << (SAMPLE_W - 1)) - 1);
    lo = WIDE_W'(-(1 << (SAMPLE_W - 1)));
    if (v > hi) begin
      sat_sample = hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      sat_sample = lo[SAMPLE_W-1:0];
    end else begin
      sat_sample = v[SAMPLE_W-1:0];
    end
  endfunction

  // ---- configuration registers ----
  logic [dcr_pkg::CFG_W-1:0]  indoor, absorb;
  logic [dcr_pkg::ROOM_W-1:0] room;

  always_ff @(posedge clk) begin
    if (rst) begin
      indoor <= dcr_pkg::INDOOR_RESET;
      room   <= dcr_pkg::ROOM_RESET;
      absorb <= dcr_pkg::ABSORB_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        dcr_pkg::REG_INDOOR: indoor <= cfg_data;
        dcr_pkg::REG_ROOM:   room   <= cfg_data[dcr_pkg::ROOM_W-1:0];
        dcr_pkg::REG_ABSORB: absorb <= cfg_data;
        default: ;
      endcase
    end
  end

  assign status.bypass = indoor < dcr_pkg::BYPASS_LIMIT;

  // ---- coefficient unit ----
  logic [Q16_W-1:0]                   a_q, b_q, m_q;
  logic [Q16_W-1:0]                   s_q, ta, tb, tc;
  logic [COEF_W-1:0]                  wet, fb, damp;
  logic [Q16_W-1:0]                   cm_a, cm_b;
  logic [CM_W-1:0]                    cm_p;
  logic [Q16_W:0]                     cm_h;
  logic [dcr_pkg::SIZE_PROD_W-1:0]    size_prod;

  always_comb begin
    a_q       = (indoor == dcr_pkg::FULL_SCALE) ? dcr_pkg::Q16_ONE : Q16_W'(indoor);
    b_q       = (absorb == dcr_pkg::FULL_SCALE) ? dcr_pkg::Q16_ONE : Q16_W'(absorb);
    m_q       = dcr_pkg::Q16_ONE - b_q;
    size_prod = dcr_pkg::SIZE_PROD_W'(room[dcr_pkg::ROOM_SMALL_W-1:0])
              * dcr_pkg::SIZE_PROD_W'(dcr_pkg::K_SIZE_RECIP);
    cm_a = '0;
    cm_b = '0;
    case (cmd.coef_step)
      dcr_pkg::CS_WET_T1: begin cm_a = s_q; cm_b = dcr_pkg::K_WET_SIZE;  end
      dcr_pkg::CS_WET_T2: begin cm_a = m_q; cm_b = dcr_pkg::K_WETM;      end
      dcr_pkg::CS_WET_A:  begin cm_a = a_q; cm_b = ta;                   end
      dcr_pkg::CS_WET:    begin cm_a = tc;  cm_b = tb;                   end
      dcr_pkg::CS_FB_S:   begin cm_a = s_q; cm_b = dcr_pkg::K_FB_SIZE;   end
      dcr_pkg::CS_FB_A:   begin cm_a = a_q; cm_b = dcr_pkg::K_FB_IND;    end
      dcr_pkg::CS_FB_M:   begin cm_a = m_q; cm_b = dcr_pkg::K_FBM;       end
      dcr_pkg::CS_FB:     begin cm_a = ta;  cm_b = tb;                   end
      dcr_pkg::CS_DAMP_S: begin cm_a = s_q; cm_b = dcr_pkg::K_DAMP_SIZE; end
      dcr_pkg::CS_DAMP_B: begin cm_a = b_q; cm_b = dcr_pkg::K_DAMP_ABS;  end
      default: ;
    endcase
    cm_p = CM_W'(cm_a) * CM_W'(cm_b);
    cm_h = cm_p[CM_W-1:Q_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (cmd.coef_en) begin
      case (cmd.coef_step)
        dcr_pkg::CS_SIZE: begin
          if (room >= dcr_pkg::ROOM_NORM) begin
            s_q <= dcr_pkg::Q16_ONE;
          end else begin
            s_q <= Q16_W'(size_prod >> dcr_pkg::SIZE_RECIP_SHIFT);
          end
        end
        dcr_pkg::CS_WET_T1: ta   <= Q16_W'(dcr_pkg::K_WET_BASE + cm_h);
        dcr_pkg::CS_WET_T2: tb   <= Q16_W'(dcr_pkg::K_WETM_BASE + cm_h);
        dcr_pkg::CS_WET_A:  tc   <= cm_h[Q16_W-1:0];
        dcr_pkg::CS_WET:    wet  <= cm_h[COEF_W-1:0];
        dcr_pkg::CS_FB_S:   ta   <= Q16_W'(dcr_pkg::K_FB_BASE + cm_h);
        dcr_pkg::CS_FB_A:   ta   <= Q16_W'({1'b0, ta} + cm_h);
        dcr_pkg::CS_FB_M:   tb   <= Q16_W'(dcr_pkg::K_FBM_BASE + cm_h);
        dcr_pkg::CS_FB:     fb   <= cm_h[COEF_W-1:0];
        dcr_pkg::CS_DAMP_S: ta   <= Q16_W'(dcr_pkg::K_DAMP_BASE - cm_h);
        dcr_pkg::CS_DAMP_B: damp <= COEF_W'({1'b0, ta} + cm_h);
        default: ;
      endcase
    end
  end

  // ---- sample, write position and fill mark ----
  logic signed [SAMPLE_W-1:0] x;
  logic                       frame;
  logic [PW-1:0]              pos;
  logic                       wrapped;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      x     <= in_data.sample_in;
      frame <= in_data.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      wrapped <= 1'b0;
    end else if (cmd.pos_adv) begin
      if (pos == PW'(DELAY_DEPTH - 1)) begin
        pos     <= '0;
        wrapped <= 1'b1;
      end else begin
        pos <= PW'(pos + 1'b1);
      end
    end
  end

  // ---- delay memory ----
  // Until the position first wraps, only words below it hold data; the rest
  // read as zero, standing in for the cleared store.
  logic signed [WORD_W-1:0] mem [MEM_DEPTH];
  logic signed [WORD_W-1:0] rdata;
  logic                     rvalid;
  logic [dcr_pkg::TAP_W-1:0] tap_d;
  logic                     tap_reached;
  logic [PW-1:0]            rd_pos;
  logic [MAW-1:0]           raddr, waddr;
  logic signed [WORD_W-1:0] wdata;

  always_comb begin
    tap_d       = dcr_pkg::COMB_TAP[cmd.rd_comb];
    tap_reached = pos >= PW'(tap_d);
    if (tap_reached) begin
      rd_pos = PW'(pos - PW'(tap_d));
    end else begin
      rd_pos = PW'(PW1'(pos) + PW1'(DELAY_DEPTH) - PW1'(tap_d));
    end
    raddr = MAW'(MAW'(cmd.rd_comb) * MAW'(DELAY_DEPTH)) + MAW'(rd_pos);
    waddr = MAW'(MAW'(cmd.wr_comb) * MAW'(DELAY_DEPTH)) + MAW'(pos);
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata  <= mem[raddr];
      rvalid <= wrapped || tap_reached;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // ---- comb arithmetic ----
  logic signed [WORD_W-1:0] lp [dcr_pkg::NCOMB];
  logic signed [WORD_W-1:0] tap_v, lp_t, sum_q, lpn;
  logic signed [DIFF_W-1:0] damp_diff, mix_diff, m1_a;
  logic        [COEF_W-1:0] m1_b;
  logic signed [COEF_W:0]   m1_bs;
  logic signed [P1_W-1:0]   p1;
  logic signed [P2_W-1:0]   p2;
  logic signed [SUM_W-1:0]  sum;
  logic signed [WIDE_W-1:0] lp_upd, w_full, y_full;
  logic signed [SAMPLE_W-1:0] y_reg;

  always_comb begin
    tap_v     = rvalid ? rdata : '0;
    lp_t      = lp[cmd.tap_comb];
    damp_diff = DIFF_W'(tap_v) - DIFF_W'(lp_t);
    sum_q     = sum[SUM_W-1:2];
    mix_diff  = DIFF_W'(sum_q) - DIFF_W'(x);
    m1_a      = cmd.mix_en ? mix_diff : damp_diff;
    m1_b      = cmd.mix_en ? wet : damp;
    m1_bs     = signed'({1'b0, m1_b});
    // one-pole low-pass as lp + (tap - lp) * damp; stays between lp and tap
    lp_upd    = WIDE_W'(lp[cmd.lp_comb]) + WIDE_W'(p1 >>> Q_SHIFT);
    w_full    = WIDE_W'(x) + WIDE_W'(p2 >>> Q_SHIFT);
    wdata     = sat_word(w_full);
    y_full    = WIDE_W'(x) + WIDE_W'(p1 >>> Q_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (cmd.tap_en || cmd.mix_en) begin
      p1 <= m1_a * m1_bs;
    end
    if (cmd.lp_en) begin
      lpn <= lp_upd[WORD_W-1:0];
    end
    if (cmd.fb_en) begin
      p2 <= lpn * signed'({1'b0, fb});
    end
    if (cmd.y_en) begin
      y_reg <= sat_sample(y_full);
    end
    if (cmd.take) begin
      sum <= '0;
    end else if (cmd.tap_en) begin
      sum <= sum + SUM_W'(tap_v);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dcr_pkg::NCOMB; i++) begin
        lp[i] <= '0;
      end
    end else if (cmd.lp_en) begin
      lp[cmd.lp_comb] <= lp_upd[WORD_W-1:0];
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.sample_out <= cmd.out_sel_x ? x : y_reg;
      out_data.frame_last <= frame;
    end
  end

endmodule

// ===== tb/sv/damped_comb_reverb_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_comb_reverb_core_tb - self-checking bench for the comb reverb core
// Drives audio beats through the core and predicts every mixed sample with a
// bit-exact copy of the four damped combs. Register settings change only while
// the core is idle. The sender idles and the receiver stalls at random in
// several patterns.
// ----------------------------------------------------------------------------
module damped_comb_reverb_core_tb;

  localparam int     DEPTH       = 4096;
  localparam int     WORD_BITS   = 20;
  localparam longint UNITY       = 65536;
  localparam longint BYPASS_FLOOR = 3277;
  localparam int     QUIET_LIMIT = 5000;
  localparam int     SOAK_BEATS  = 160;
  localparam int     BEATS_PER_SETTING = 40;
  localparam int     COMB_DELAY [4] = '{1559, 2137, 2909, 3823};

  // Register index with no register behind it
  localparam logic [dcr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Idling pattern per random phase, in percent: none, sender, receiver, both
  localparam int SEND_IDLE [4] = '{0, 75, 0, 35};
  localparam int RECV_STALL [4] = '{0, 0, 75, 35};

  // Second setting of each random phase sits on a corner of the registers
  localparam logic [dcr_pkg::CFG_W-1:0] EDGE_INDOOR [4] =
    '{16'd65534, 16'd3276, 16'd3277, 16'hFFFF};
  localparam logic [dcr_pkg::CFG_W-1:0] EDGE_ROOM   [4] =
    '{16'd0, 16'd201, 16'hFFFF, 16'd199};
  localparam logic [dcr_pkg::CFG_W-1:0] EDGE_ABSORB [4] =
    '{16'hFFFF, 16'd32768, 16'd0, 16'd1};

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  dcr_pkg::in_item_t             in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  dcr_pkg::out_item_t            out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [dcr_pkg::CFG_IDX_W-1:0] cfg_index = dcr_pkg::REG_INDOOR;
  logic [dcr_pkg::CFG_W-1:0]     cfg_data  = '0;

  // Beats waiting to be driven, and mixed samples waiting to come out
  dcr_pkg::in_item_t  sample_q [$];
  dcr_pkg::out_item_t mix_q [$];

  // Predictor state: register copies, delay lines, damping low-passes
  logic [dcr_pkg::CFG_W-1:0]  indoor_reg = dcr_pkg::INDOOR_RESET;
  logic [dcr_pkg::ROOM_W-1:0] room_reg   = dcr_pkg::ROOM_RESET;
  logic [dcr_pkg::CFG_W-1:0]  absorb_reg = dcr_pkg::ABSORB_RESET;
  int delay_line [0:4*DEPTH-1];
  int lp_state [4];
  int write_pos;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int n_errors = 0;
  int n_reverb = 0;
  int n_bypass = 0;
  int n_writes = 0;
  int n_out = 0;
  int quiet = 0;

  damped_comb_reverb_core #(
    .DELAY_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint clamp_to(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Work out the mixed sample for one accepted beat and advance the combs
  function automatic void predict_mix(input dcr_pkg::in_item_t beat);
    longint x, a, b, s, t1, t2, wet, fb, damp, tap, lp, acc, y;
    int rd;
    int c;
    dcr_pkg::out_item_t r;
    x = $signed(beat.sample_in);
    r.frame_last = beat.frame_end;
    a = (indoor_reg == 16'hFFFF) ? UNITY : longint'(indoor_reg);
    if (a < BYPASS_FLOOR) begin
      // dry sample passes, the combs and the write position hold
      r.sample_out = beat.sample_in;
      n_bypass++;
      mix_q.push_back(r);
      return;
    end
    b = (absorb_reg == 16'hFFFF) ? UNITY : longint'(absorb_reg);
    s = (longint'(room_reg) * UNITY) / 200;
    if (s > UNITY) s = UNITY;

    t1 = 13107 + ((s * 22938) >> 16);
    t2 = 19661 + (((UNITY - b) * 45875) >> 16);
    wet = (((a * t1) >> 16) * t2) >> 16;
    t1 = 22938 + ((s * 26214) >> 16) + ((a * 9830) >> 16);
    t2 = 26214 + (((UNITY - b) * 39322) >> 16);
    fb = (t1 * t2) >> 16;
    damp = 36045 - ((s * 19661) >> 16) + ((b * 13107) >> 16);

    acc = 0;
    for (c = 0; c < 4; c++) begin
      rd = (write_pos + DEPTH - COMB_DELAY[c]) % DEPTH;
      tap = delay_line[c*DEPTH + rd];
      lp = (longint'(lp_state[c]) * (UNITY - damp) + tap * damp) >>> 16;
      lp = clamp_to(lp, WORD_BITS);
      lp_state[c] = int'(lp);
      delay_line[c*DEPTH + write_pos] = int'(clamp_to(x + ((lp * fb) >>> 16), WORD_BITS));
      acc += tap;
    end
    write_pos = (write_pos + 1) % DEPTH;

    acc = acc >>> 2;
    y = clamp_to((x * (UNITY - wet) + acc * wet) >>> 16, 16);
    r.sample_out = y[15:0];
    n_reverb++;
    mix_q.push_back(r);
  endfunction

  // Driver: present the next pending beat, hold it until taken, idle at random
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_mix(in_data);
      if (!in_valid || in_ready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= sample_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each output beat with the oldest predicted sample
  always @(posedge clk) begin : monitor_blk
    dcr_pkg::out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_out++;
        if (mix_q.size() == 0) begin
          $error("unexpected output beat: sample_out %0d frame_last %0b",
                 $signed(out_data.sample_out), out_data.frame_last);
          n_errors++;
        end else begin
          want = mix_q.pop_front();
          if (out_data.sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, got %0d",
                   $signed(want.sample_out), $signed(out_data.sample_out));
            n_errors++;
          end
          if (out_data.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0b, got %0b", want.frame_last, out_data.frame_last);
            n_errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: drop the run if no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic queue_beat(input logic [15:0] smp, input logic fe);
    dcr_pkg::in_item_t it;
    it.sample_in = smp;
    it.frame_end = fe;
    sample_q.push_back(it);
  endtask

  // Mostly full-range noise, with rails and near-silence mixed in
  task automatic queue_random(input int count);
    int i;
    logic [15:0] smp;
    for (i = 0; i < count; i++) begin
      case ($urandom_range(7))
        0:       smp = 16'h7FFF;
        1:       smp = 16'h8000;
        2:       smp = 16'($urandom_range(63)) - 16'd32;
        default: smp = 16'($urandom_range(16'hFFFF));
      endcase
      queue_beat(smp, $urandom_range(7) == 0);
    end
  endtask

  // Write one register and mirror it in the predictor's copy
  task automatic write_reg(input logic [dcr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dcr_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_writes++;
    case (idx)
      dcr_pkg::REG_INDOOR: indoor_reg = value;
      dcr_pkg::REG_ROOM:   room_reg   = value[dcr_pkg::ROOM_W-1:0];
      dcr_pkg::REG_ABSORB: absorb_reg = value;
      default:             ;
    endcase
  endtask

  task automatic write_setting(input logic [dcr_pkg::CFG_W-1:0] indoor,
                               input logic [dcr_pkg::CFG_W-1:0] room,
                               input logic [dcr_pkg::CFG_W-1:0] absorb);
    write_reg(dcr_pkg::REG_INDOOR, indoor);
    write_reg(dcr_pkg::REG_ROOM, room);
    write_reg(dcr_pkg::REG_ABSORB, absorb);
  endtask

  // Hold the stimulus until every predicted sample is out, then let the
  // core settle before anything else is touched
  task automatic wait_drained();
    while (sample_q.size() != 0 || in_valid || mix_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    int p;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset registers: indoor amount zero, so the dry sample passes
    queue_beat(16'h0000, 1'b0);
    queue_beat(16'h7FFF, 1'b1);
    queue_beat(16'h8000, 1'b0);
    queue_beat(16'hFFFF, 1'b1);
    queue_beat(16'h0001, 1'b0);
    wait_drained();

    // Just below the bypass threshold
    write_reg(dcr_pkg::REG_INDOOR, 16'd3276);
    queue_beat(16'h5555, 1'b1);
    queue_beat(16'hAAAA, 1'b0);
    wait_drained();

    // Exactly on the threshold, room at the clamp point, no absorption
    write_setting(16'd3277, 16'd200, 16'd0);
    queue_beat(16'h7FFF, 1'b0);
    queue_beat(16'h8000, 1'b1);
    queue_beat(16'h0000, 1'b0);
    queue_beat(16'h0001, 1'b1);
    queue_beat(16'hFFFF, 1'b0);
    wait_drained();

    // An unused register index must leave the settings alone
    write_reg(REG_UNUSED, 16'hFFFF);
    queue_beat(16'h7FFF, 1'b1);
    queue_beat(16'h8000, 1'b0);
    wait_drained();

    // Full indoor amount, room 200 with junk in the high bits: a burst of
    // noise with rails that drives the feedback words towards saturation
    write_setting(16'hFFFF, 16'hF0C8, 16'd0);
    queue_random(SOAK_BEATS);
    wait_drained();

    for (p = 0; p < 4; p++) begin
      send_idle_pct  = SEND_IDLE[p];
      recv_stall_pct = RECV_STALL[p];
      write_setting(16'($urandom_range(65535, 3277)), 16'($urandom_range(16'hFFFF)),
                    16'($urandom_range(16'hFFFF)));
      queue_random(BEATS_PER_SETTING);
      wait_drained();
      write_setting(EDGE_INDOOR[p], EDGE_ROOM[p], EDGE_ABSORB[p]);
      queue_random(BEATS_PER_SETTING);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mix_q.size() != 0) begin
      $error("%0d predicted samples never came out", mix_q.size());
      n_errors++;
    end

    $display("Run covered %0d reverb and %0d bypassed samples, %0d output beats checked,",
             n_reverb, n_bypass, n_out);
    $display("over %0d register writes and four sender/receiver idling patterns.", n_writes);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
